FILE: src/fcr_pkg.sv
// Shared constants, types and helper functions for the cube root core.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps
package fcr_pkg;

  localparam int EW = 12;
  typedef logic signed [EW-1:0] exp_t;

  localparam logic [31:0] CBRT_MAGIC = 32'h2A517D91;
  localparam logic [31:0] RECIP3     = 32'hAAAAAAAB;
  localparam logic [31:0] THIRD_BITS = 32'h3EAAAAAB;
  localparam logic [31:0] TWO_BITS   = 32'h40000000;
  localparam logic [31:0] QNAN_BITS  = 32'h7FC00000;
  localparam logic [31:0] PINF_BITS  = 32'h7F800000;

  localparam int MUL_LAT    = 3;
  localparam int ADD_LAT    = 4;
  localparam int DIV_BPS    = 2;
  localparam int DIV_QBITS  = 26;
  localparam int DIV_STEPS  = DIV_QBITS / DIV_BPS;
  localparam int DIV_LAT    = DIV_STEPS + 2;
  localparam int NEWTON_LAT = 2 * MUL_LAT + DIV_LAT + ADD_LAT;
  localparam int GUESS_LAT  = 2;
  localparam int CORE_LAT   = GUESS_LAT + 2 * NEWTON_LAT + 1;

  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
    logic sign;
  } fcls_t;

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic       found;
    n = 6'd48;
    found = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!found && v[i]) begin
        found = 1'b1;
        n = 6'(47 - i);
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd28;
    found = 1'b0;
    for (int i = 27; i >= 0; i--) begin
      if (!found && v[i]) begin
        found = 1'b1;
        n = 5'(27 - i);
      end
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] n;
    logic       found;
    n = 5'd24;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found && v[i]) begin
        found = 1'b1;
        n = 5'(23 - i);
      end
    end
    return n;
  endfunction

  // sig: [25] leading one, [24:2] fraction, [1] guard, [0] sticky.
  // e: biased exponent of the leading one; denormalize when below one.
  function automatic logic [31:0] round_pack(input logic s, input exp_t e,
                                             input logic [25:0] sig);
    exp_t        diff;
    logic [5:0]  sh;
    logic [25:0] shs;
    logic [25:0] mask;
    logic [7:0]  ef;
    logic        inc;
    logic [30:0] mag;
    diff = exp_t'(1) - e;
    if (e < exp_t'(1)) begin
      sh = (diff > exp_t'(26)) ? 6'd26 : diff[5:0];
      ef = 8'd0;
    end else begin
      sh = 6'd0;
      ef = e[7:0];
    end
    mask = ~({26{1'b1}} << sh);
    shs = sig >> sh;
    shs[0] = shs[0] | (|(sig & mask));
    inc = shs[1] & (shs[0] | shs[2]);
    mag = {ef, shs[24:2]} + 31'(inc);
    if (e >= exp_t'(255)) begin
      return {s, PINF_BITS[30:0]};
    end
    return {s, mag};
  endfunction

  function automatic fcls_t classify(input logic [31:0] v);
    fcls_t c;
    c.nan  = (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    c.inf  = (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    c.zero = (v[30:23] == 8'h00) && (v[22:0] == 23'd0);
    c.sign = v[31];
    return c;
  endfunction

endpackage

FILE: src/float_cube_root_newton_core.sv
// Cube root core: bit-trick first guess, then two Newton steps in float.
// A start passes the guess stages, both Newton steps and the output register.
// Throughput one word per cycle; busy stays low, the divider is fully pipelined.
// The receiver cannot stall: each result shows for exactly one cycle.
// rst_ni (async, active low) clears all valid bits; data registers are not reset.
// Depends on fcr_pkg, fcr_newton and the float units below it.
`timescale 1ns / 1ps
module float_cube_root_newton_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] x_bits_i,
  output logic        valid_o,
  output logic [31:0] root_bits_o
);

  logic        acc;
  logic [31:0] mag;
  logic [63:0] prod;

  // Guess stage 1: |x as integer| / 3 by reciprocal multiply.
  logic        g1_v_q;
  logic        g1_neg_q;
  logic [30:0] g1_quo_q;
  logic [31:0] g1_x_q;

  // Guess stage 2: restore sign, add the magic constant.
  logic [31:0] quo_s;
  logic        g2_v_q;
  logic [31:0] g2_x_q, g2_y_q;

  logic        n1_v, n2_v;
  logic [31:0] n1_x, n1_y, n2_x, n2_y;

  logic        out_v_q;
  logic [31:0] root_d, root_q;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  always_comb begin
    mag  = x_bits_i[31] ? (~x_bits_i + 32'd1) : x_bits_i;
    prod = 64'(mag) * 64'(fcr_pkg::RECIP3);
  end

  always_comb begin
    quo_s = g1_neg_q ? (32'd0 - {1'b0, g1_quo_q}) : {1'b0, g1_quo_q};
  end

  always_ff @(posedge clk_i) begin
    g1_neg_q <= x_bits_i[31];
    g1_quo_q <= prod[63:33];
    g1_x_q   <= x_bits_i;
    g2_x_q   <= g1_x_q;
    g2_y_q   <= quo_s + fcr_pkg::CBRT_MAGIC;
  end

  fcr_newton u_step1 (
    .clk_i, .rst_ni, .valid_i(g2_v_q), .x_i(g2_x_q), .y_i(g2_y_q),
    .valid_o(n1_v), .x_o(n1_x), .y_o(n1_y)
  );

  fcr_newton u_step2 (
    .clk_i, .rst_ni, .valid_i(n1_v), .x_i(n1_x), .y_i(n1_y),
    .valid_o(n2_v), .x_o(n2_x), .y_o(n2_y)
  );

  // Fold every NaN to the canonical quiet NaN.
  always_comb begin
    if ((n2_y[30:23] == 8'hFF) && (n2_y[22:0] != 23'd0)) begin
      root_d = fcr_pkg::QNAN_BITS;
    end else begin
      root_d = n2_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_v_q  <= 1'b0;
      g2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      g1_v_q  <= acc;
      g2_v_q  <= g1_v_q;
      out_v_q <= n2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d;
  end

  assign valid_o     = out_v_q;
  assign root_bits_o = root_q;

`ifndef ASSERT_OFF
  // A strobe only ever follows a start taken exactly one latency earlier.
  a_strobe_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start & ~busy, fcr_pkg::CORE_LAT))
    else $error("result strobe without matching start");

  // The x word carried down the pipe must still be the one that entered.
  a_x_carried: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n2_v |-> (n2_x == $past(x_bits_i, fcr_pkg::CORE_LAT - 1)))
    else $error("x word lost its alignment with the guess");

  // A NaN input must come out as the canonical quiet NaN.
  a_nan_in_nan_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && ($past(x_bits_i[30:23], fcr_pkg::CORE_LAT) == 8'hFF)
      && ($past(x_bits_i[22:0], fcr_pkg::CORE_LAT) != 23'd0))
    |-> (root_bits_o == fcr_pkg::QNAN_BITS))
    else $error("NaN input did not give canonical NaN");
`endif

endmodule

FILE: src/fcr_fmul.sv
// Three-stage single-precision multiplier, round to nearest even.
// Depends on fcr_pkg.
`timescale 1ns / 1ps
module fcr_fmul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        valid_o,
  output logic [31:0] res_o
);

  fcr_pkg::fcls_t ca, cb, c1_d, c1_q, c2_q;
  logic [47:0]    p_d, p_q;
  fcr_pkg::exp_t  e1_d, e1_q, e2_d, e2_q;
  logic [5:0]     lz;
  logic [47:0]    pn;
  logic [25:0]    sig_d, sig_q;
  logic [2:0]     v_q;
  logic [31:0]    res_d, res_q;

  always_comb begin
    ca = fcr_pkg::classify(a_i);
    cb = fcr_pkg::classify(b_i);
    c1_d.nan  = ca.nan | cb.nan | (ca.inf & cb.zero) | (ca.zero & cb.inf);
    c1_d.inf  = ca.inf | cb.inf;
    c1_d.zero = ca.zero | cb.zero;
    c1_d.sign = ca.sign ^ cb.sign;
    p_d = 48'({|a_i[30:23], a_i[22:0]}) * 48'({|b_i[30:23], b_i[22:0]});
    e1_d = fcr_pkg::exp_t'({4'b0, (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23]})
         + fcr_pkg::exp_t'({4'b0, (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23]})
         - fcr_pkg::exp_t'(126);
  end

  always_comb begin
    lz = fcr_pkg::lzc48(p_q);
    pn = p_q << lz;
    e2_d = e1_q - fcr_pkg::exp_t'({6'b0, lz});
    sig_d = {pn[47:23], |pn[22:0]};
  end

  always_comb begin
    if (c2_q.nan) begin
      res_d = fcr_pkg::QNAN_BITS;
    end else if (c2_q.inf) begin
      res_d = {c2_q.sign, fcr_pkg::PINF_BITS[30:0]};
    end else if (c2_q.zero) begin
      res_d = {c2_q.sign, 31'd0};
    end else begin
      res_d = fcr_pkg::round_pack(c2_q.sign, e2_q, sig_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q  <= c1_d;
    p_q   <= p_d;
    e1_q  <= e1_d;
    c2_q  <= c1_q;
    e2_q  <= e2_d;
    sig_q <= sig_d;
    res_q <= res_d;
  end

  assign valid_o = v_q[2];
  assign res_o   = res_q;

endmodule

FILE: src/fcr_fadd.sv
// Four-stage single-precision adder: align, add, normalize, round.
// Depends on fcr_pkg.
`timescale 1ns / 1ps
module fcr_fadd (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        valid_o,
  output logic [31:0] res_o
);

  fcr_pkg::fcls_t ca, cb, c1_d, c1_q, c2_d, c2_q, c3_q;
  logic [31:0]    big, sml;
  logic [7:0]     eb, es, d;
  logic [4:0]     sh;
  logic [26:0]    big_d, big_q, sm27, sm_d, sm_q, mask;
  logic           sub_d, sub_q, sub2_q, sub3_q;
  fcr_pkg::exp_t  e1_d, e1_q, e2_q, e3_d, e3_q;
  logic [27:0]    sum_d, sum_q, sn;
  logic [4:0]     lz;
  logic [25:0]    sig_d, sig_q;
  logic [3:0]     v_q;
  logic [31:0]    res_d, res_q;

  always_comb begin
    ca = fcr_pkg::classify(a_i);
    cb = fcr_pkg::classify(b_i);
    if (a_i[30:0] >= b_i[30:0]) begin
      big = a_i;
      sml = b_i;
    end else begin
      big = b_i;
      sml = a_i;
    end
    sub_d = a_i[31] ^ b_i[31];
    eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d  = eb - es;
    sh = (d > 8'd27) ? 5'd27 : d[4:0];
    big_d = {|big[30:23], big[22:0], 3'b000};
    sm27  = {|sml[30:23], sml[22:0], 3'b000};
    mask  = ~({27{1'b1}} << sh);
    sm_d  = sm27 >> sh;
    sm_d[0] = sm_d[0] | (|(sm27 & mask));
    c1_d.nan  = ca.nan | cb.nan | (ca.inf & cb.inf & sub_d);
    c1_d.inf  = ca.inf | cb.inf;
    c1_d.zero = 1'b0;
    c1_d.sign = big[31];
    e1_d = fcr_pkg::exp_t'({4'b0, eb});
  end

  always_comb begin
    sum_d = sub_q ? ({1'b0, big_q} - {1'b0, sm_q}) : ({1'b0, big_q} + {1'b0, sm_q});
    c2_d      = c1_q;
    c2_d.zero = (sum_d == 28'd0);
  end

  always_comb begin
    lz = fcr_pkg::lzc28(sum_q);
    sn = sum_q << lz;
    e3_d = e2_q + fcr_pkg::exp_t'(1) - fcr_pkg::exp_t'({7'b0, lz});
    sig_d = {sn[27:3], |sn[2:0]};
  end

  always_comb begin
    if (c3_q.nan) begin
      res_d = fcr_pkg::QNAN_BITS;
    end else if (c3_q.inf) begin
      res_d = {c3_q.sign, fcr_pkg::PINF_BITS[30:0]};
    end else if (c3_q.zero) begin
      res_d = {c3_q.sign & ~sub3_q, 31'd0};
    end else begin
      res_d = fcr_pkg::round_pack(c3_q.sign, e3_q, sig_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q   <= c1_d;
    big_q  <= big_d;
    sm_q   <= sm_d;
    sub_q  <= sub_d;
    e1_q   <= e1_d;
    c2_q   <= c2_d;
    sub2_q <= sub_q;
    e2_q   <= e1_q;
    sum_q  <= sum_d;
    c3_q   <= c2_q;
    sub3_q <= sub2_q;
    e3_q   <= e3_d;
    sig_q  <= sig_d;
    res_q  <= res_d;
  end

  assign valid_o = v_q[3];
  assign res_o   = res_q;

endmodule

FILE: src/fcr_fdiv.sv
// Pipelined single-precision divider: normalize, restoring quotient
// stages of two bits each, round. Depends on fcr_pkg.
`timescale 1ns / 1ps
module fcr_fdiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] n_i,
  input  logic [31:0] d_i,
  output logic        valid_o,
  output logic [31:0] res_o
);

  typedef struct packed {
    fcr_pkg::fcls_t              c;
    fcr_pkg::exp_t               e;
    logic [24:0]                 rem;
    logic [23:0]                 md;
    logic [fcr_pkg::DIV_QBITS-1:0] q;
  } dstage_t;

  fcr_pkg::fcls_t cn, cd;
  logic [23:0]    ma, mb, mn, md;
  logic [4:0]     lza, lzb;
  fcr_pkg::exp_t  en, ed;
  dstage_t        s0_d;
  dstage_t        st_q [fcr_pkg::DIV_STEPS+1];
  logic           v_q  [fcr_pkg::DIV_STEPS+2];
  logic [25:0]    sig;
  logic [31:0]    res_d, res_q;
  dstage_t        last;

  always_comb begin
    cn = fcr_pkg::classify(n_i);
    cd = fcr_pkg::classify(d_i);
    ma = {|n_i[30:23], n_i[22:0]};
    mb = {|d_i[30:23], d_i[22:0]};
    lza = fcr_pkg::lzc24(ma);
    lzb = fcr_pkg::lzc24(mb);
    mn = ma << lza;
    md = mb << lzb;
    en = fcr_pkg::exp_t'({4'b0, (n_i[30:23] == 8'd0) ? 8'd1 : n_i[30:23]})
       - fcr_pkg::exp_t'({7'b0, lza});
    ed = fcr_pkg::exp_t'({4'b0, (d_i[30:23] == 8'd0) ? 8'd1 : d_i[30:23]})
       - fcr_pkg::exp_t'({7'b0, lzb});
    s0_d.c.nan  = cn.nan | cd.nan | (cn.zero & cd.zero) | (cn.inf & cd.inf);
    s0_d.c.inf  = (cn.inf & ~cd.inf) | (cd.zero & ~cn.zero);
    s0_d.c.zero = (cn.zero & ~cd.zero) | (cd.inf & ~cn.inf);
    s0_d.c.sign = cn.sign ^ cd.sign;
    s0_d.md = md;
    s0_d.q  = '0;
    // Pre-scale so the quotient lands in [1, 2).
    if (mn < md) begin
      s0_d.rem = {mn, 1'b0};
      s0_d.e   = en - ed + fcr_pkg::exp_t'(126);
    end else begin
      s0_d.rem = {1'b0, mn};
      s0_d.e   = en - ed + fcr_pkg::exp_t'(127);
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= s0_d;
  end

  for (genvar k = 0; k < fcr_pkg::DIV_STEPS; k++) begin : g_step
    dstage_t nx;
    always_comb begin
      nx = st_q[k];
      for (int j = 0; j < fcr_pkg::DIV_BPS; j++) begin
        if (nx.rem >= {1'b0, nx.md}) begin
          nx.rem = nx.rem - {1'b0, nx.md};
          nx.q   = {nx.q[fcr_pkg::DIV_QBITS-2:0], 1'b1};
        end else begin
          nx.q   = {nx.q[fcr_pkg::DIV_QBITS-2:0], 1'b0};
        end
        nx.rem = {nx.rem[23:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      st_q[k+1] <= nx;
    end
  end

  always_comb begin
    last = st_q[fcr_pkg::DIV_STEPS];
    sig  = {last.q[25:1], last.q[0] | (last.rem != 25'd0)};
    if (last.c.nan) begin
      res_d = fcr_pkg::QNAN_BITS;
    end else if (last.c.inf) begin
      res_d = {last.c.sign, fcr_pkg::PINF_BITS[30:0]};
    end else if (last.c.zero) begin
      res_d = {last.c.sign, 31'd0};
    end else begin
      res_d = fcr_pkg::round_pack(last.c.sign, last.e, sig);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fcr_pkg::DIV_STEPS + 2; i++) begin
        v_q[i] <= 1'b0;
      end
    end else begin
      v_q[0] <= valid_i;
      for (int i = 1; i < fcr_pkg::DIV_STEPS + 2; i++) begin
        v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = v_q[fcr_pkg::DIV_STEPS+1];
  assign res_o   = res_q;

endmodule

FILE: src/fcr_newton.sv
// One Newton step y' = third * (2*y + x/(y*y)) as a chain of float units.
// Depends on fcr_pkg, fcr_fmul, fcr_fdiv and fcr_fadd.
`timescale 1ns / 1ps
module fcr_newton (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] x_i,
  input  logic [31:0] y_i,
  output logic        valid_o,
  output logic [31:0] x_o,
  output logic [31:0] y_o
);

  logic        sq_v, tw_v, q_v, s_v;
  logic [31:0] sq, tw, q, s;
  logic [31:0] x_pipe  [fcr_pkg::NEWTON_LAT];
  logic [31:0] tw_pipe [fcr_pkg::DIV_LAT];

  fcr_fmul u_sq (
    .clk_i, .rst_ni, .valid_i(valid_i), .a_i(y_i), .b_i(y_i),
    .valid_o(sq_v), .res_o(sq)
  );

  fcr_fmul u_twice (
    .clk_i, .rst_ni, .valid_i(valid_i), .a_i(fcr_pkg::TWO_BITS), .b_i(y_i),
    .valid_o(tw_v), .res_o(tw)
  );

  fcr_fdiv u_div (
    .clk_i, .rst_ni, .valid_i(sq_v & tw_v), .n_i(x_pipe[fcr_pkg::MUL_LAT-1]),
    .d_i(sq), .valid_o(q_v), .res_o(q)
  );

  fcr_fadd u_add (
    .clk_i, .rst_ni, .valid_i(q_v), .a_i(tw_pipe[fcr_pkg::DIV_LAT-1]), .b_i(q),
    .valid_o(s_v), .res_o(s)
  );

  fcr_fmul u_third (
    .clk_i, .rst_ni, .valid_i(s_v), .a_i(fcr_pkg::THIRD_BITS), .b_i(s),
    .valid_o(valid_o), .res_o(y_o)
  );

  // Carry x beside the arithmetic and hold 2*y until the quotient arrives.
  always_ff @(posedge clk_i) begin
    x_pipe[0] <= x_i;
    for (int i = 1; i < fcr_pkg::NEWTON_LAT; i++) begin
      x_pipe[i] <= x_pipe[i-1];
    end
    tw_pipe[0] <= tw;
    for (int i = 1; i < fcr_pkg::DIV_LAT; i++) begin
      tw_pipe[i] <= tw_pipe[i-1];
    end
  end

  assign x_o = x_pipe[fcr_pkg::NEWTON_LAT-1];

endmodule
